// ===== sv/evww_pkg.sv =====
// ----------------------------------------------------------------------------
// evww_pkg: shared types and codes for the event wait/wake unit
// Holds the operation, event kind, command, outcome and sequencer state codes.
// ----------------------------------------------------------------------------
package evww_pkg;

	// input operation codes
	localparam logic OP_SET  = 1'b0;
	localparam logic OP_WAIT = 1'b1;

	// event kind register codes
	localparam logic KIND_AUTO   = 1'b0;
	localparam logic KIND_MANUAL = 1'b1;

	// command classes handed from the front end to the back end
	typedef enum logic [1:0] {
		CMD_WAIT_AUTO,
		CMD_WAIT_MANUAL,
		CMD_SET_AUTO,
		CMD_SET_MANUAL
	} cmd_kind_t;

	// result outcome codes
	typedef enum logic [2:0] {
		OC_GRANTED   = 3'd0,
		OC_BLOCKED   = 3'd1,
		OC_WOKEN     = 3'd2,
		OC_NO_WAITER = 3'd3,
		OC_FULL      = 3'd4
	} outcome_t;

	// back end sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WAKE,
		ST_READ
	} back_state_t;

	// handshake between the front end queue and the back end
	typedef struct packed {
		logic      valid;
		cmd_kind_t kind;
	} cmd_ctrl_t;

endpackage

// ===== sv/evww_front.sv =====
// ----------------------------------------------------------------------------
// evww_front: input queue and command classification
// Holds the event kind register, classifies each transaction and queues it.
// ----------------------------------------------------------------------------
module evww_front import evww_pkg::*; #(
	parameter int ID_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic               operation,
	input  logic [ID_BITS-1:0] thread_id,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	output cmd_ctrl_t          cmd,
	output logic [ID_BITS-1:0] cmd_tid,
	input  logic               cmd_take
);

	logic               kind_q;
	cmd_kind_t          kind_q_arr [2];
	logic [ID_BITS-1:0] tid_q      [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               do_push;
	logic               do_pop;
	cmd_kind_t          new_kind;

	assign cfg_ready = 1'b1;
	assign full      = (cnt_q == 2'd2);
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && (cnt_q != 2'd0);

	always_comb begin
		unique case ({operation, kind_q})
			{OP_WAIT, KIND_AUTO}:   new_kind = CMD_WAIT_AUTO;
			{OP_WAIT, KIND_MANUAL}: new_kind = CMD_WAIT_MANUAL;
			{OP_SET, KIND_AUTO}:    new_kind = CMD_SET_AUTO;
			default:                new_kind = CMD_SET_MANUAL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= KIND_AUTO;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (cfg_valid && cfg_ready)
				kind_q <= cfg_data;
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			kind_q_arr[wr_ptr_q] <= new_kind;
			tid_q[wr_ptr_q]      <= thread_id;
		end
	end

	assign cmd.valid = (cnt_q != 2'd0);
	assign cmd.kind  = kind_q_arr[rd_ptr_q];
	assign cmd_tid   = tid_q[rd_ptr_q];

endmodule

// ===== sv/evww_back.sv =====
// ----------------------------------------------------------------------------
// evww_back: event state, waiter queue and result queue
// Executes queued commands against the flag and the waiter FIFO memory.
// ----------------------------------------------------------------------------
module evww_back import evww_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_ctrl_t          cmd,
	input  logic [ID_BITS-1:0] cmd_tid,
	output logic               cmd_take,
	output logic               empty,
	input  logic               pop,
	output logic [2:0]         outcome,
	output logic [ID_BITS-1:0] woken_id,
	output logic               last
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	back_state_t        state_q, state_d;
	logic               flag_q;
	logic               manual_q;
	logic [PTR_W-1:0]   oldest_q;
	logic [CNT_W-1:0]   count_q;
	logic [ID_BITS-1:0] mem [QUEUE_DEPTH];
	logic [ID_BITS-1:0] rd_data_q;

	// result queue
	outcome_t           res_oc_q   [2];
	logic [ID_BITS-1:0] res_id_q   [2];
	logic               res_last_q [2];
	logic               res_wr_q;
	logic               res_rd_q;
	logic [1:0]         res_cnt_q;
	logic               res_space;
	logic               res_pop;

	// control from the sequencer
	logic               res_push;
	outcome_t           res_oc;
	logic [ID_BITS-1:0] res_id;
	logic               res_last;
	logic               mem_we;
	logic               flag_set;
	logic               flag_clr;
	logic               cnt_inc;
	logic               deq;
	logic               start_wake;
	logic               more;

	logic [PTR_W:0]     wsum;
	logic [PTR_W-1:0]   waddr;
	logic               q_full;
	logic               q_some;

	assign res_space = (res_cnt_q != 2'd2);
	assign res_pop   = pop && !empty;
	assign q_full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_some    = (count_q != '0);
	assign more      = manual_q && (count_q > CNT_W'(1));

	// tail slot, wrapped over the queue depth
	always_comb begin
		wsum = (PTR_W + 1)'(oldest_q) + (PTR_W + 1)'(count_q);
		if (wsum >= (PTR_W + 1)'(QUEUE_DEPTH))
			wsum = wsum - (PTR_W + 1)'(QUEUE_DEPTH);
		waddr = wsum[PTR_W-1:0];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid && res_space && q_some &&
				    (cmd.kind == CMD_SET_AUTO || cmd.kind == CMD_SET_MANUAL))
					state_d = ST_WAKE;
			end
			ST_WAKE: begin
				if (res_space)
					state_d = more ? ST_READ : ST_IDLE;
			end
			ST_READ: state_d = ST_WAKE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd_take   = 1'b0;
		res_push   = 1'b0;
		res_oc     = OC_GRANTED;
		res_id     = cmd_tid;
		res_last   = 1'b1;
		mem_we     = 1'b0;
		flag_set   = 1'b0;
		flag_clr   = 1'b0;
		cnt_inc    = 1'b0;
		deq        = 1'b0;
		start_wake = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.valid && res_space) begin
					cmd_take = 1'b1;
					unique case (cmd.kind)
						CMD_WAIT_AUTO, CMD_WAIT_MANUAL: begin
							res_push = 1'b1;
							priority if (flag_q) begin
								res_oc   = OC_GRANTED;
								flag_clr = (cmd.kind == CMD_WAIT_AUTO);
							end else if (q_full) begin
								res_oc = OC_FULL;
							end else begin
								res_oc  = OC_BLOCKED;
								mem_we  = 1'b1;
								cnt_inc = 1'b1;
							end
						end
						default: begin
							flag_set = (cmd.kind == CMD_SET_MANUAL) || !q_some;
							if (q_some) begin
								start_wake = 1'b1;
							end else begin
								res_push = 1'b1;
								res_oc   = OC_NO_WAITER;
								res_id   = '0;
							end
						end
					endcase
				end
			end
			ST_WAKE: begin
				if (res_space) begin
					res_push = 1'b1;
					res_oc   = OC_WOKEN;
					res_id   = rd_data_q;
					res_last = !more;
					deq      = 1'b1;
					flag_clr = !manual_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			flag_q    <= 1'b0;
			manual_q  <= 1'b0;
			oldest_q  <= '0;
			count_q   <= '0;
			res_wr_q  <= 1'b0;
			res_rd_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			state_q <= state_d;
			if (flag_set)
				flag_q <= 1'b1;
			else if (flag_clr)
				flag_q <= 1'b0;
			if (start_wake)
				manual_q <= (cmd.kind == CMD_SET_MANUAL);
			if (cnt_inc)
				count_q <= count_q + CNT_W'(1);
			else if (deq)
				count_q <= count_q - CNT_W'(1);
			if (deq)
				oldest_q <= (oldest_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : oldest_q + PTR_W'(1);
			if (res_push)
				res_wr_q <= ~res_wr_q;
			if (res_pop)
				res_rd_q <= ~res_rd_q;
			res_cnt_q <= res_cnt_q + {1'b0, res_push} - {1'b0, res_pop};
		end
	end

	// waiter memory: one write port, one registered read at the oldest slot
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[waddr] <= cmd_tid;
		rd_data_q <= mem[oldest_q];
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_oc_q[res_wr_q]   <= res_oc;
			res_id_q[res_wr_q]   <= res_id;
			res_last_q[res_wr_q] <= res_last;
		end
	end

	assign empty    = (res_cnt_q == 2'd0);
	assign outcome  = res_oc_q[res_rd_q];
	assign woken_id = res_id_q[res_rd_q];
	assign last     = res_last_q[res_rd_q];

endmodule

// ===== sv/event_wait_wake_unit.sv =====
// ----------------------------------------------------------------------------
// event_wait_wake_unit: hardware event object with a FIFO of waiting threads
// Top level: front end input queue, back end sequencer with waiter memory.
// ----------------------------------------------------------------------------
// Users push set and wait transactions in at the left and pop results at the
// right, both sides behaving as queues. A two-entry command queue and a
// two-entry result queue let either side stall without holding the other.
// Flow through the back end sequencer: a wait, or a set that finds no
// waiter, is answered straight from ST_IDLE; a set that wakes a waiter
// moves to ST_WAKE to push its result, as the waiter memory is read
// through a registered port; a set on a manual-reset event alternates
// ST_WAKE and ST_READ to drain every waiter in order, the last one marked.
// The event kind is written through the cfg channel (always ready) and
// must only change while no transaction is in flight. The waiter memory
// needs no clearing pass: only slots written by a blocked wait are ever read.
// ----------------------------------------------------------------------------
module event_wait_wake_unit import evww_pkg::*; #(
	parameter int QUEUE_DEPTH = 16,
	parameter int ID_BITS     = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	// input queue side
	input  logic               push,
	output logic               full,
	input  logic               operation,
	input  logic [ID_BITS-1:0] thread_id,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data,
	// result queue side
	output logic               empty,
	input  logic               pop,
	output logic [2:0]         outcome,
	output logic [ID_BITS-1:0] woken_id,
	output logic               last
);

	// command handoff between the two halves
	cmd_ctrl_t          cmd;
	logic [ID_BITS-1:0] cmd_tid;
	logic               cmd_take;

	// Classify each accepted transaction by operation and event kind, hold it.
	evww_front #(
		.ID_BITS (ID_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.thread_id (thread_id),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.cmd_tid   (cmd_tid),
		.cmd_take  (cmd_take)
	);

	// Advance the flag and the waiter FIFO, drop results into the result queue.
	evww_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_tid  (cmd_tid),
		.cmd_take (cmd_take),
		.empty    (empty),
		.pop      (pop),
		.outcome  (outcome),
		.woken_id (woken_id),
		.last     (last)
	);

endmodule

// ===== dv/event_wait_wake_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_wait_wake_unit_tb: self-checking regression for the event wait/wake unit
// Drives set and wait transactions with random gaps and back-pressure. It
// switches the event kind between phases and predicts every result from a
// local model of the flag and the waiter FIFO.
// ----------------------------------------------------------------------------
module event_wait_wake_unit_tb;
	import evww_pkg::*;

	localparam int QDEPTH       = 16;
	localparam int ID_W         = 8;
	localparam int IDLE_PCT     = 14;   // share of cycles either side idles
	localparam int DRAIN_CYCLES = 8;    // settle time after the last result
	localparam int HOLD_CYCLES  = 80;   // long receiver hold-off
	localparam int MAX_REPORTS  = 10;

	// one expected result transaction
	typedef struct packed {
		outcome_t        oc;
		logic [ID_W-1:0] id;
		logic            last;
	} wake_result_t;

	// ------------------------------------------------------------------------
	// Event model: tracks the kind register, the signaled flag and the waiter
	// FIFO, and keeps the results each accepted transaction should produce.
	// ------------------------------------------------------------------------
	class event_scoreboard;
		logic            kind;
		logic            flag;
		logic [ID_W-1:0] waiters [QDEPTH];
		int unsigned     head;
		int unsigned     count;
		wake_result_t    expected_q [$];
		int              n_fail;

		function new();
			kind   = KIND_AUTO;
			flag   = 1'b0;
			head   = 0;
			count  = 0;
			n_fail = 0;
		endfunction

		function void set_kind(logic k);
			kind = k;
		endfunction

		function int unsigned outstanding();
			return expected_q.size();
		endfunction

		function void add(outcome_t oc, logic [ID_W-1:0] id, logic lst);
			wake_result_t r;
			r.oc   = oc;
			r.id   = id;
			r.last = lst;
			expected_q.push_back(r);
		endfunction

		function logic [ID_W-1:0] take_oldest();
			logic [ID_W-1:0] id;
			id    = waiters[head];
			head  = (head + 1) % QDEPTH;
			count = count - 1;
			return id;
		endfunction

		function void mismatch(string msg);
			n_fail++;
			if (n_fail <= MAX_REPORTS)
				$display("%0t ERROR: %s", $time, msg);
		endfunction

		// advance the model by one accepted set or wait
		function void note_item(logic op, logic [ID_W-1:0] tid);
			logic [ID_W-1:0] id;
			if (op == OP_WAIT) begin
				if (flag) begin
					if (kind == KIND_AUTO)
						flag = 1'b0;
					add(OC_GRANTED, tid, 1'b1);
				end else if (count >= QDEPTH) begin
					add(OC_FULL, tid, 1'b1);
				end else begin
					waiters[(head + count) % QDEPTH] = tid;
					count = count + 1;
					add(OC_BLOCKED, tid, 1'b1);
				end
			end else if (kind == KIND_AUTO) begin
				if (count != 0) begin
					id   = take_oldest();
					flag = 1'b0;
					add(OC_WOKEN, id, 1'b1);
				end else begin
					flag = 1'b1;
					add(OC_NO_WAITER, '0, 1'b1);
				end
			end else begin
				flag = 1'b1;
				if (count == 0)
					add(OC_NO_WAITER, '0, 1'b1);
				while (count != 0) begin
					id = take_oldest();
					add(OC_WOKEN, id, count == 0);
				end
			end
		endfunction

		// compare one popped result with the oldest expectation
		function void check_result(logic [2:0] oc, logic [ID_W-1:0] id, logic lst);
			wake_result_t r;
			if (expected_q.size() == 0) begin
				mismatch($sformatf("unexpected result outcome=%0d id=0x%02h last=%0b",
					oc, id, lst));
				return;
			end
			r = expected_q.pop_front();
			if (oc !== r.oc || id !== r.id || lst !== r.last)
				mismatch($sformatf("outcome exp=%0d act=%0d id exp=0x%02h act=0x%02h last exp=%0b act=%0b",
					r.oc, oc, r.id, id, r.last, lst));
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            push;
	logic            full;
	logic            operation;
	logic [ID_W-1:0] thread_id;
	logic            cfg_valid;
	logic            cfg_ready;
	logic            cfg_data;
	logic            empty;
	logic            pop;
	logic [2:0]      outcome;
	logic [ID_W-1:0] woken_id;
	logic            last;

	event_scoreboard sb;

	// stimulus-owned controls read by the receiver process
	bit calm;       // no idling on either side while set
	int hold_req;   // bump to request a long receiver hold-off

	event_wait_wake_unit #(
		.QUEUE_DEPTH(QDEPTH),
		.ID_BITS    (ID_W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.operation(operation),
		.thread_id(thread_id),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.empty    (empty),
		.pop      (pop),
		.outcome  (outcome),
		.woken_id (woken_id),
		.last     (last)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Sample at the rising edge: every value read here is the pre-edge one, so
	// each transaction is seen exactly as the block sees it. Note inputs before
	// checking, a result never comes from an input accepted at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_kind(cfg_data);
			if (push && !full)
				sb.note_item(operation, thread_id);
			if (pop && !empty)
				sb.check_result(outcome, woken_id, last);
		end
	end

	// Receiver: pop at random, pop every cycle in a calm stretch, and hold off
	// completely for a long run of cycles when the stimulus asks for it.
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				pop <= 1'b0;
				hold_left--;
			end else if (calm) begin
				pop <= 1'b1;
			end else begin
				pop <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Offer one transaction and hold it until accepted. Push is left high so
	// a following transaction can go out at the very edge of acceptance.
	task automatic send_item(logic op, logic [ID_W-1:0] tid);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		push      <= 1'b1;
		operation <= op;
		thread_id <= tid;
		do @(posedge clk); while (full);
	endtask

	// drop push after the last transaction of a burst
	task automatic stop_push();
		push <= 1'b0;
	endtask

	// Step one edge first so the sampler has noted the last accepted
	// transaction, then wait for every expected result and let it settle.
	task automatic wait_drained();
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write the event kind, only with nothing in flight
	task automatic write_kind(logic k);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= k;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [ID_W-1:0] random_id();
		int sel;
		sel = $urandom_range(19);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		return ID_W'($urandom_range(255));
	endfunction

	initial begin
		int wait_pct;
		sb        = new();
		calm      = 1'b0;
		hold_req  = 0;
		arst_n    = 1'b0;
		push      = 1'b0;
		operation = OP_SET;
		thread_id = '0;
		cfg_valid = 1'b0;
		cfg_data  = KIND_AUTO;
		pop       = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: auto-reset event first.
		write_kind(KIND_AUTO);
		send_item(OP_SET, 8'h00);      // no waiter: flag goes up
		send_item(OP_WAIT, 8'h00);     // granted, flag cleared
		send_item(OP_WAIT, 8'hFF);     // blocked
		send_item(OP_SET, 8'h00);      // wakes 0xFF
		// fill the FIFO, then one more wait is rejected as queue full
		for (int i = 0; i < QDEPTH; i++)
			send_item(OP_WAIT, ID_W'(i * 17));
		send_item(OP_WAIT, 8'hA5);
		stop_push();

		// Manual-reset: a set drains the whole FIFO in order, last marked.
		write_kind(KIND_MANUAL);
		send_item(OP_SET, 8'h00);
		send_item(OP_SET, 8'hFF);      // no waiter left, flag stays up
		send_item(OP_WAIT, 8'h5A);     // granted, flag kept
		send_item(OP_WAIT, 8'hC3);
		stop_push();

		// Kind change with the flag up: the first auto wait consumes it.
		write_kind(KIND_AUTO);
		send_item(OP_WAIT, 8'h3C);
		send_item(OP_WAIT, 8'h81);     // blocked, carried into random phases
		stop_push();

		// Random phases: the mix of waits varies so phases reach both a full
		// FIFO and long manual drains; the kind changes between phases.
		for (int ph = 0; ph < 5; ph++) begin
			if (ph == 0)
				write_kind(KIND_MANUAL);
			else if (ph == 1)
				write_kind(KIND_AUTO);
			else
				write_kind(logic'($urandom_range(1)));
			wait_pct = $urandom_range(90, 30);
			for (int n = 0; n < 15; n++)
				send_item(($urandom_range(99) < wait_pct) ? OP_WAIT : OP_SET, random_id());
			stop_push();
		end

		// Back-pressure: hold the receiver off while the sender keeps offering,
		// so both queues fill and full stalls the input; then run calm.
		write_kind(KIND_MANUAL);
		calm = 1'b1;
		hold_req++;
		for (int n = 0; n < 20; n++)
			send_item(($urandom_range(99) < 70) ? OP_WAIT : OP_SET, random_id());
		stop_push();
		wait_drained();
		calm = 1'b0;

		repeat (4 * DRAIN_CYCLES) @(posedge clk);
		if (sb.n_fail == 0 && sb.outstanding() == 0)
			$display("event_wait_wake_unit regression: pass");
		else
			$display("event_wait_wake_unit regression: fail");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("event_wait_wake_unit regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/evww_pkg.sv
sv/evww_front.sv
sv/evww_back.sv
sv/event_wait_wake_unit.sv
dv/event_wait_wake_unit_tb.sv
